[src/talsg_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths, command and phase codes for the two-axis line step generator.
// No dependencies.
package talsg_pkg;

  localparam int POS_BITS  = 24;
  localparam int FRAC_BITS = 16;

  // magnitude of the most negative coordinate counts double, so one extra bit
  localparam int MAG_BITS  = POS_BITS + 1;
  localparam int HALF_BITS = MAG_BITS + 1;
  localparam int BUSY_BITS = POS_BITS + 1;
  localparam int NUM_BITS  = MAG_BITS + FRAC_BITS;
  localparam int ACC_BITS  = NUM_BITS + 1;
  localparam int GY_BITS   = ACC_BITS - FRAC_BITS + 1;
  localparam int CNT_BITS  = $clog2(NUM_BITS + 1);

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_MOVE_REL = 3'd1,
    CMD_MOVE_ABS = 3'd2,
    CMD_SET_POS  = 3'd3,
    CMD_ENABLE   = 3'd4,
    CMD_DISABLE  = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    PH_X    = 4'b0001,
    PH_Y    = 4'b0010,
    PH_FREE = 4'b0100,
    PH_OFF  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic [2:0]                 command;
    logic signed [POS_BITS-1:0] coord_x;
    logic signed [POS_BITS-1:0] coord_y;
  } in_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] x_position;
    logic signed [POS_BITS-1:0] y_position;
    logic [BUSY_BITS-1:0]       busy_count;
    logic                       move_refused;
    logic                       step_x_level;
    logic                       step_y_level;
    logic                       dir_x_level;
    logic                       dir_y_level;
    logic                       driver_disable;
  } out_t;

  // distance magnitude; the most negative value maps to 2^POS_BITS
  function automatic logic [MAG_BITS-1:0] mag_of(input logic [POS_BITS-1:0] v);
    logic [POS_BITS-1:0] neg_v;
    neg_v = '0 - v;
    if (v == {1'b1, {(POS_BITS-1){1'b0}}}) begin
      mag_of = MAG_BITS'(1) << POS_BITS;
    end else if (v[POS_BITS-1]) begin
      mag_of = {1'b0, neg_v};
    end else begin
      mag_of = {1'b0, v};
    end
  endfunction

endpackage

[src/talsg_div.sv]
`timescale 1ns / 1ps
// Bit-serial restoring divider that forms the fixed-point slope, one quotient bit a cycle.
// Depends on talsg_pkg.
module talsg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [talsg_pkg::NUM_BITS-1:0] dividend,
  input  logic [talsg_pkg::MAG_BITS-1:0] divisor,
  output logic                           done,
  output logic [talsg_pkg::NUM_BITS-1:0] quotient
);

  logic [talsg_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;
  logic [talsg_pkg::MAG_BITS-1:0] rem_r, rem_nxt;
  logic [talsg_pkg::MAG_BITS-1:0] dvs_r, dvs_nxt;
  logic [talsg_pkg::NUM_BITS-1:0] quo_r, quo_nxt;
  logic [talsg_pkg::MAG_BITS:0]   trial;
  logic                           fits;

  // quo_r shifts dividend bits out at the top and quotient bits in at the bottom
  assign trial = {rem_r, quo_r[talsg_pkg::NUM_BITS-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      cnt_nxt = talsg_pkg::CNT_BITS'(talsg_pkg::NUM_BITS);
      run_nxt = 1'b1;
      rem_nxt = '0;
      dvs_nxt = divisor;
      quo_nxt = dividend;
    end else if (run_r) begin
      if (fits) begin
        rem_nxt = talsg_pkg::MAG_BITS'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[talsg_pkg::MAG_BITS-1:0];
      end
      quo_nxt = {quo_r[talsg_pkg::NUM_BITS-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == talsg_pkg::CNT_BITS'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[src/two_axis_line_step_generator_top.sv]
`timescale 1ns / 1ps
// Two-axis straight-line step generator: command decode, phase machine, step pins.
// Depends on talsg_pkg and talsg_div.
//
// Usage: each input word carries one command (tick, relative move, absolute move,
// set position, enable or disable drivers) with two signed coordinates. Every
// accepted word yields exactly one result word with the positions, the remaining
// half-step count and the five pin levels as they stand after the command.
// Ticks, position sets, driver commands, refused moves and moves with zero X
// distance: the result is registered at the accepting edge and shows the next
// cycle. A move with nonzero X distance runs the bit-serial slope divider, one
// quotient bit per cycle over NUM_BITS (41) bits; once it is done the block
// waits until the result register is free and then registers the result.
// A new word is taken once the block is idle and the result register is free
// or being read in the same cycle. If the receiver holds out_ready low, the
// result waits in the output register and no further word is taken.
// Reset (rst_n low, synchronous) clears positions, counts, grants and the
// slope, puts the phase machine in its off state and drives every pin low.
module two_axis_line_step_generator_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  talsg_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output talsg_pkg::out_t   out_data
);

  talsg_pkg::state_t                  state_r, state_nxt;
  talsg_pkg::phase_t                  phase_r, phase_nxt;
  logic [talsg_pkg::POS_BITS-1:0]     pos_x_r, pos_x_nxt;
  logic [talsg_pkg::POS_BITS-1:0]     pos_y_r, pos_y_nxt;
  logic [talsg_pkg::HALF_BITS-1:0]    hs_x_r, hs_x_nxt;
  logic [talsg_pkg::HALF_BITS-1:0]    hs_y_r, hs_y_nxt;
  logic                               neg_x_r, neg_x_nxt;
  logic                               neg_y_r, neg_y_nxt;
  logic [1:0]                         gx_r, gx_nxt;
  logic [talsg_pkg::GY_BITS-1:0]      gy_r, gy_nxt;
  logic [talsg_pkg::NUM_BITS-1:0]     slope_r, slope_nxt;
  logic [talsg_pkg::FRAC_BITS-1:0]    frac_r, frac_nxt;
  logic                               step_x_r, step_x_nxt;
  logic                               step_y_r, step_y_nxt;
  logic                               dir_x_r, dir_x_nxt;
  logic                               dir_y_r, dir_y_nxt;
  logic                               cs_r, cs_nxt;
  logic                               out_valid_r, out_valid_nxt;
  talsg_pkg::out_t                    out_data_r, out_word;

  logic                               in_fire;
  logic                               out_free;
  logic                               busy;
  logic                               refused;
  logic                               load_out;
  logic                               div_start;
  logic                               div_done;
  logic [talsg_pkg::NUM_BITS-1:0]     div_quo;
  logic [talsg_pkg::POS_BITS-1:0]     dx_w, dy_w;
  logic [talsg_pkg::MAG_BITS-1:0]     ax_w, ay_w;
  logic [talsg_pkg::ACC_BITS-1:0]     acc_w;
  logic [talsg_pkg::HALF_BITS:0]      busy_sum;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == talsg_pkg::ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign busy     = (hs_x_r != '0) || (hs_y_r != '0);

  assign dx_w = (in_data.command == talsg_pkg::CMD_MOVE_ABS) ? in_data.coord_x - pos_x_r
                                                             : in_data.coord_x;
  assign dy_w = (in_data.command == talsg_pkg::CMD_MOVE_ABS) ? in_data.coord_y - pos_y_r
                                                             : in_data.coord_y;
  assign ax_w = talsg_pkg::mag_of(dx_w);
  assign ay_w = talsg_pkg::mag_of(dy_w);

  assign acc_w = talsg_pkg::ACC_BITS'(frac_r) + talsg_pkg::ACC_BITS'(slope_r);

  talsg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({ay_w, {talsg_pkg::FRAC_BITS{1'b0}}}),
    .divisor  (ax_w),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    logic [1:0]                    gx_t;
    logic [talsg_pkg::GY_BITS-1:0] gy_t;
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    hs_x_nxt   = hs_x_r;
    hs_y_nxt   = hs_y_r;
    neg_x_nxt  = neg_x_r;
    neg_y_nxt  = neg_y_r;
    gx_nxt     = gx_r;
    gy_nxt     = gy_r;
    slope_nxt  = slope_r;
    frac_nxt   = frac_r;
    step_x_nxt = step_x_r;
    step_y_nxt = step_y_r;
    dir_x_nxt  = dir_x_r;
    dir_y_nxt  = dir_y_r;
    cs_nxt     = cs_r;
    refused    = 1'b0;
    load_out   = 1'b0;
    div_start  = 1'b0;
    gx_t       = gx_r;
    gy_t       = gy_r;

    case (state_r)
      talsg_pkg::ST_IDLE: begin
        if (in_fire) begin
          load_out = 1'b1;
          case (in_data.command)
            talsg_pkg::CMD_TICK: begin
              // new grants only once both previous grants are used up
              if (gx_r == '0 && gy_r == '0) begin
                case (phase_r)
                  talsg_pkg::PH_FREE: gy_t = talsg_pkg::GY_BITS'(2);
                  talsg_pkg::PH_X: begin
                    gx_t      = 2'd2;
                    phase_nxt = talsg_pkg::PH_Y;
                  end
                  talsg_pkg::PH_Y: begin
                    gy_t      = {acc_w[talsg_pkg::ACC_BITS-1:talsg_pkg::FRAC_BITS], 1'b0};
                    frac_nxt  = acc_w[talsg_pkg::FRAC_BITS-1:0];
                    phase_nxt = talsg_pkg::PH_X;
                  end
                  default: ;
                endcase
              end
              // odd count means falling edge, which moves the position
              if (hs_x_r != '0 && gx_t != '0) begin
                if (hs_x_r[0]) begin
                  step_x_nxt = 1'b0;
                  pos_x_nxt  = neg_x_r ? pos_x_r - 1'b1 : pos_x_r + 1'b1;
                end else begin
                  step_x_nxt = 1'b1;
                end
                hs_x_nxt = hs_x_r - 1'b1;
                gx_t     = gx_t - 1'b1;
              end
              if (hs_y_r != '0 && gy_t != '0) begin
                if (hs_y_r[0]) begin
                  step_y_nxt = 1'b0;
                  pos_y_nxt  = neg_y_r ? pos_y_r - 1'b1 : pos_y_r + 1'b1;
                end else begin
                  step_y_nxt = 1'b1;
                end
                hs_y_nxt = hs_y_r - 1'b1;
                gy_t     = gy_t - 1'b1;
              end
              if (hs_y_nxt == '0) gy_t = '0;
              if (hs_x_nxt == '0) gx_t = '0;
              gx_nxt = gx_t;
              gy_nxt = gy_t;
            end
            talsg_pkg::CMD_MOVE_REL, talsg_pkg::CMD_MOVE_ABS: begin
              if (busy) begin
                refused = 1'b1;
              end else begin
                cs_nxt    = 1'b0;
                gx_nxt    = '0;
                gy_nxt    = '0;
                phase_nxt = talsg_pkg::PH_OFF;
                // a zero-distance axis keeps its sign and direction pin
                if (ax_w != '0) begin
                  neg_x_nxt = dx_w[talsg_pkg::POS_BITS-1];
                  dir_x_nxt = !dx_w[talsg_pkg::POS_BITS-1];
                  hs_x_nxt  = {ax_w, 1'b0};
                end
                if (ay_w != '0) begin
                  neg_y_nxt = dy_w[talsg_pkg::POS_BITS-1];
                  dir_y_nxt = !dy_w[talsg_pkg::POS_BITS-1];
                  hs_y_nxt  = {ay_w, 1'b0};
                end
                if (ax_w == '0) begin
                  phase_nxt = talsg_pkg::PH_FREE;
                end else begin
                  load_out  = 1'b0;
                  div_start = 1'b1;
                  state_nxt = talsg_pkg::ST_DIV;
                end
              end
            end
            talsg_pkg::CMD_SET_POS: begin
              pos_x_nxt = in_data.coord_x;
              pos_y_nxt = in_data.coord_y;
            end
            talsg_pkg::CMD_ENABLE:  cs_nxt = 1'b0;
            talsg_pkg::CMD_DISABLE: cs_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      talsg_pkg::ST_DIV: begin
        if (div_done) begin
          slope_nxt = div_quo;
          frac_nxt  = '0;
          phase_nxt = talsg_pkg::PH_X;
          state_nxt = talsg_pkg::ST_DONE;
        end
      end
      talsg_pkg::ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = talsg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = talsg_pkg::ST_IDLE;
    endcase
  end

  // result word reflects the state after the command
  assign busy_sum = {1'b0, hs_x_nxt} + {1'b0, hs_y_nxt};

  always_comb begin
    out_word.x_position = pos_x_nxt;
    out_word.y_position = pos_y_nxt;
    if (busy_sum[talsg_pkg::HALF_BITS:talsg_pkg::BUSY_BITS] != '0) begin
      out_word.busy_count = '1;
    end else begin
      out_word.busy_count = busy_sum[talsg_pkg::BUSY_BITS-1:0];
    end
    out_word.move_refused   = refused;
    out_word.step_x_level   = step_x_nxt;
    out_word.step_y_level   = step_y_nxt;
    out_word.dir_x_level    = dir_x_nxt;
    out_word.dir_y_level    = dir_y_nxt;
    out_word.driver_disable = cs_nxt;
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= talsg_pkg::ST_IDLE;
      phase_r     <= talsg_pkg::PH_OFF;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      hs_x_r      <= '0;
      hs_y_r      <= '0;
      neg_x_r     <= 1'b0;
      neg_y_r     <= 1'b0;
      gx_r        <= '0;
      gy_r        <= '0;
      slope_r     <= '0;
      frac_r      <= '0;
      step_x_r    <= 1'b0;
      step_y_r    <= 1'b0;
      dir_x_r     <= 1'b0;
      dir_y_r     <= 1'b0;
      cs_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      hs_x_r      <= hs_x_nxt;
      hs_y_r      <= hs_y_nxt;
      neg_x_r     <= neg_x_nxt;
      neg_y_r     <= neg_y_nxt;
      gx_r        <= gx_nxt;
      gy_r        <= gy_nxt;
      slope_r     <= slope_nxt;
      frac_r      <= frac_nxt;
      step_x_r    <= step_x_nxt;
      step_y_r    <= step_y_nxt;
      dir_x_r     <= dir_x_nxt;
      dir_y_r     <= dir_y_nxt;
      cs_r        <= cs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_data_r <= out_word;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == talsg_pkg::ST_DIV)
    else $error("slope divider finished outside the divide state");

  a_gx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    hs_x_r == '0 |-> gx_r == '0)
    else $error("x grant left over with no x half-steps");

  a_gx_max: assert property (@(posedge clk) disable iff (!rst_n)
    gx_r != 2'd3)
    else $error("x grant above two half-steps");

  a_set_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.command == talsg_pkg::CMD_SET_POS |=>
      pos_x_r == $past(in_data.coord_x) && pos_y_r == $past(in_data.coord_y))
    else $error("set position not taken");

  a_move_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !busy && ax_w != '0 &&
    (in_data.command == talsg_pkg::CMD_MOVE_REL ||
     in_data.command == talsg_pkg::CMD_MOVE_ABS) |=> state_r == talsg_pkg::ST_DIV)
    else $error("accepted move did not start the slope divide");

endmodule

[verif/step_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the two-axis line step generator: mirrors positions, half-step counts,
// grants, slope and pins per accepted command word and checks every result word.
// Depends on talsg_pkg.
module step_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  talsg_pkg::in_t  in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  talsg_pkg::out_t out_data,
  output int              errors,
  output int              pending
);

  logic [talsg_pkg::POS_BITS-1:0]  pos_x, pos_y;
  logic [talsg_pkg::HALF_BITS-1:0] half_x, half_y;
  logic                            neg_x, neg_y;
  logic [1:0]                      grant_x;
  logic [talsg_pkg::GY_BITS-1:0]   grant_y;
  talsg_pkg::phase_t               phase;
  logic [talsg_pkg::NUM_BITS-1:0]  slope;
  logic [talsg_pkg::FRAC_BITS-1:0] frac;
  logic                            pin_step_x, pin_step_y, pin_dir_x, pin_dir_y, pin_cs;
  talsg_pkg::out_t                 predicted_status[$];
  int                              fail_count = 0;

  task automatic clear_state();
    pos_x      = '0;
    pos_y      = '0;
    half_x     = '0;
    half_y     = '0;
    neg_x      = 1'b0;
    neg_y      = 1'b0;
    grant_x    = '0;
    grant_y    = '0;
    phase      = talsg_pkg::PH_OFF;
    slope      = '0;
    frac       = '0;
    pin_step_x = 1'b0;
    pin_step_y = 1'b0;
    pin_dir_x  = 1'b0;
    pin_dir_y  = 1'b0;
    pin_cs     = 1'b0;
  endtask

  // the most negative coordinate counts as 2^POS_BITS steps
  function automatic logic [talsg_pkg::MAG_BITS-1:0] distance_of(
    input logic [talsg_pkg::POS_BITS-1:0] v);
    logic [talsg_pkg::POS_BITS-1:0] flipped;
    flipped = ~v + 1'b1;
    if (!v[talsg_pkg::POS_BITS-1]) return {1'b0, v};
    if (flipped == v) return talsg_pkg::MAG_BITS'(1) << talsg_pkg::POS_BITS;
    return {1'b0, flipped};
  endfunction

  task automatic start_line(input logic [talsg_pkg::POS_BITS-1:0] dx,
                            input logic [talsg_pkg::POS_BITS-1:0] dy);
    logic [talsg_pkg::MAG_BITS-1:0] ax, ay;
    ax      = distance_of(dx);
    ay      = distance_of(dy);
    pin_cs  = 1'b0;
    grant_x = '0;
    grant_y = '0;
    // a zero-distance axis keeps its old direction
    if (ax != 0) begin
      neg_x     = dx[talsg_pkg::POS_BITS-1];
      pin_dir_x = ~dx[talsg_pkg::POS_BITS-1];
      half_x    = {ax, 1'b0};
    end
    if (ay != 0) begin
      neg_y     = dy[talsg_pkg::POS_BITS-1];
      pin_dir_y = ~dy[talsg_pkg::POS_BITS-1];
      half_y    = {ay, 1'b0};
    end
    if (ax == 0) begin
      phase = talsg_pkg::PH_FREE;
    end else begin
      slope = {ay, {talsg_pkg::FRAC_BITS{1'b0}}} / talsg_pkg::NUM_BITS'(ax);
      frac  = '0;
      phase = talsg_pkg::PH_X;
    end
  endtask

  task automatic advance_tick();
    logic [talsg_pkg::ACC_BITS-1:0] acc;
    if (grant_x == 0 && grant_y == 0) begin
      case (phase)
        talsg_pkg::PH_FREE: grant_y = talsg_pkg::GY_BITS'(2);
        talsg_pkg::PH_X: begin
          grant_x = 2'd2;
          phase   = talsg_pkg::PH_Y;
        end
        talsg_pkg::PH_Y: begin
          // integer part of the running slope sum goes to Y, fraction carries over
          acc     = talsg_pkg::ACC_BITS'(slope) + talsg_pkg::ACC_BITS'(frac);
          grant_y = {acc[talsg_pkg::ACC_BITS-1:talsg_pkg::FRAC_BITS], 1'b0};
          frac    = acc[talsg_pkg::FRAC_BITS-1:0];
          phase   = talsg_pkg::PH_X;
        end
        default: ;
      endcase
    end
    if (half_x != 0 && grant_x != 0) begin
      if (half_x[0]) begin
        pin_step_x = 1'b0;
        pos_x      = neg_x ? pos_x - 1'b1 : pos_x + 1'b1;
      end else begin
        pin_step_x = 1'b1;
      end
      half_x  = half_x - 1'b1;
      grant_x = grant_x - 1'b1;
    end
    if (half_y != 0 && grant_y != 0) begin
      if (half_y[0]) begin
        pin_step_y = 1'b0;
        pos_y      = neg_y ? pos_y - 1'b1 : pos_y + 1'b1;
      end else begin
        pin_step_y = 1'b1;
      end
      half_y  = half_y - 1'b1;
      grant_y = grant_y - 1'b1;
    end
    if (half_y == 0) grant_y = '0;
    if (half_x == 0) grant_x = '0;
  endtask

  task automatic apply_command(input talsg_pkg::in_t w, output talsg_pkg::out_t r);
    logic                           busy, refused;
    logic [talsg_pkg::HALF_BITS:0]  total;
    busy    = (half_x != 0) || (half_y != 0);
    refused = 1'b0;
    case (w.command)
      talsg_pkg::CMD_TICK: advance_tick();
      talsg_pkg::CMD_MOVE_REL, talsg_pkg::CMD_MOVE_ABS: begin
        if (busy) begin
          refused = 1'b1;
        end else if (w.command == talsg_pkg::CMD_MOVE_REL) begin
          start_line(w.coord_x, w.coord_y);
        end else begin
          start_line(w.coord_x - pos_x, w.coord_y - pos_y);
        end
      end
      talsg_pkg::CMD_SET_POS: begin
        pos_x = w.coord_x;
        pos_y = w.coord_y;
      end
      talsg_pkg::CMD_ENABLE: pin_cs = 1'b0;
      talsg_pkg::CMD_DISABLE: pin_cs = 1'b1;
      default: ;
    endcase
    total            = {1'b0, half_x} + {1'b0, half_y};
    r.x_position     = pos_x;
    r.y_position     = pos_y;
    r.busy_count     = ((total >> talsg_pkg::BUSY_BITS) != 0) ? '1 :
                       total[talsg_pkg::BUSY_BITS-1:0];
    r.move_refused   = refused;
    r.step_x_level   = pin_step_x;
    r.step_y_level   = pin_step_y;
    r.dir_x_level    = pin_dir_x;
    r.dir_y_level    = pin_dir_y;
    r.driver_disable = pin_cs;
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    talsg_pkg::out_t want, fresh;
    if (!rst_n) begin
      clear_state();
      predicted_status.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_status.size() == 0) begin
          $display("%0t: result word with none expected, got %h", $time, out_data);
          fail_count++;
        end else begin
          want = predicted_status.pop_front();
          check_field("x_position", 32'(want.x_position), 32'(out_data.x_position));
          check_field("y_position", 32'(want.y_position), 32'(out_data.y_position));
          check_field("busy_count", 32'(want.busy_count), 32'(out_data.busy_count));
          check_field("move_refused", 32'(want.move_refused),
                      32'(out_data.move_refused));
          check_field("step_x_level", 32'(want.step_x_level),
                      32'(out_data.step_x_level));
          check_field("step_y_level", 32'(want.step_y_level),
                      32'(out_data.step_y_level));
          check_field("dir_x_level", 32'(want.dir_x_level), 32'(out_data.dir_x_level));
          check_field("dir_y_level", 32'(want.dir_y_level), 32'(out_data.dir_y_level));
          check_field("driver_disable", 32'(want.driver_disable),
                      32'(out_data.driver_disable));
        end
      end
      if (in_valid && in_ready) begin
        apply_command(in_data, fresh);
        predicted_status.push_back(fresh);
      end
    end
    errors  <= fail_count;
    pending <= predicted_status.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Top of the two-axis line step generator testbench: clock, reset, command stimulus,
// receiver back-pressure, watchdog and verdict. Depends on talsg_pkg, step_checker.
module tb;

  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 440;
  localparam int SETTLE_SPAN  = 60;
  localparam logic [2:0] CMD_RESERVED_A = 3'd6;
  localparam logic [2:0] CMD_RESERVED_B = 3'd7;
  localparam logic [talsg_pkg::POS_BITS-1:0] POS_MAX =
    {1'b0, {(talsg_pkg::POS_BITS-1){1'b1}}};
  localparam logic [talsg_pkg::POS_BITS-1:0] POS_MIN =
    {1'b1, {(talsg_pkg::POS_BITS-1){1'b0}}};

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  talsg_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_ready = 1'b0;
  talsg_pkg::out_t out_data;

  int                              errors, pending;
  int                              idle_pct = 0;
  int                              stall_pct = 0;
  logic                            hold_req = 1'b0;
  int                              hold_done = 0;
  int                              quiet = 0;
  int                              words_sent = 0;
  logic [talsg_pkg::BUSY_BITS-1:0] last_busy = '0;

  always #4 clk = ~clk;

  two_axis_line_step_generator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  step_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending)
  );

  // receiver: one long hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_req && hold_done < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_done <= hold_done + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) last_busy <= out_data.busy_count;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_word(input logic [2:0] cmd,
                           input logic [talsg_pkg::POS_BITS-1:0] cx,
                           input logic [talsg_pkg::POS_BITS-1:0] cy);
    talsg_pkg::in_t w;
    w.command = cmd;
    w.coord_x = cx;
    w.coord_y = cy;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // stop offering and wait until every result word is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_until_idle();
    int rounds;
    rounds = 0;
    do begin
      send_word(talsg_pkg::CMD_TICK, '0, '0);
      settle();
      rounds++;
    end while (last_busy != 0 && rounds < 400);
  endtask

  function automatic int pick_dist();
    int r, mag;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 75) mag = $urandom_range(8, 1);
    else if (r < 95) mag = $urandom_range(30, 9);
    else mag = $urandom_range(60, 31);
    return $urandom_range(1) ? -mag : mag;
  endfunction

  task automatic noise_word();
    int sel;
    sel = $urandom_range(5);
    case (sel)
      0: send_word(talsg_pkg::CMD_SET_POS, talsg_pkg::POS_BITS'($urandom()),
                   talsg_pkg::POS_BITS'($urandom()));
      1: send_word(talsg_pkg::CMD_ENABLE, talsg_pkg::POS_BITS'($urandom()),
                   talsg_pkg::POS_BITS'($urandom()));
      2: send_word(talsg_pkg::CMD_DISABLE, talsg_pkg::POS_BITS'($urandom()),
                   talsg_pkg::POS_BITS'($urandom()));
      3: send_word(talsg_pkg::CMD_MOVE_REL, talsg_pkg::POS_BITS'(pick_dist()),
                   talsg_pkg::POS_BITS'(pick_dist()));
      4: send_word($urandom_range(1) ? CMD_RESERVED_A : CMD_RESERVED_B,
                   talsg_pkg::POS_BITS'($urandom()), talsg_pkg::POS_BITS'($urandom()));
      default: send_word(talsg_pkg::CMD_TICK, talsg_pkg::POS_BITS'($urandom()),
                         talsg_pkg::POS_BITS'($urandom()));
    endcase
  endtask

  // one move followed by roughly enough ticks to finish it
  task automatic line_sequence();
    int                             dx, dy, ax, ay, need, ticks;
    logic [talsg_pkg::POS_BITS-1:0] base_x, base_y;
    dx = pick_dist();
    dy = pick_dist();
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if ($urandom_range(2) == 0) begin
      base_x = talsg_pkg::POS_BITS'($urandom());
      base_y = talsg_pkg::POS_BITS'($urandom());
      send_word(talsg_pkg::CMD_SET_POS, base_x, base_y);
      send_word(talsg_pkg::CMD_MOVE_ABS, base_x + talsg_pkg::POS_BITS'(dx),
                base_y + talsg_pkg::POS_BITS'(dy));
    end else begin
      send_word(talsg_pkg::CMD_MOVE_REL, talsg_pkg::POS_BITS'(dx),
                talsg_pkg::POS_BITS'(dy));
    end
    need  = (ax == 0) ? 2 * ay + 2 : 3 * ax + 2 * ay + 6;
    ticks = ($urandom_range(4) == 0) ? $urandom_range(need) : need + $urandom_range(3);
    repeat (ticks) begin
      if ($urandom_range(29) == 0) noise_word();
      else send_word(talsg_pkg::CMD_TICK, talsg_pkg::POS_BITS'($urandom()),
                     talsg_pkg::POS_BITS'($urandom()));
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(99) < 80) line_sequence();
      else noise_word();
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: wrap-around absolute move, refused move, pins, free Y, lone X, null move
    send_word(talsg_pkg::CMD_TICK, '0, '0);
    send_word(talsg_pkg::CMD_SET_POS, POS_MAX, POS_MIN);
    send_word(talsg_pkg::CMD_MOVE_ABS, POS_MIN, POS_MAX);
    send_word(talsg_pkg::CMD_MOVE_REL, talsg_pkg::POS_BITS'(5), talsg_pkg::POS_BITS'(5));
    repeat (4) send_word(talsg_pkg::CMD_TICK, '0, '0);
    send_word(talsg_pkg::CMD_DISABLE, '0, '0);
    send_word(talsg_pkg::CMD_MOVE_REL, '0, talsg_pkg::POS_BITS'(2));
    repeat (4) send_word(talsg_pkg::CMD_TICK, '0, '0);
    send_word(talsg_pkg::CMD_ENABLE, '1, '1);
    send_word(talsg_pkg::CMD_MOVE_REL, talsg_pkg::POS_BITS'(-2), '0);
    repeat (6) send_word(talsg_pkg::CMD_TICK, '0, '0);
    send_word(talsg_pkg::CMD_MOVE_REL, '0, '0);
    send_word(CMD_RESERVED_A, POS_MAX, POS_MIN);
    send_word(CMD_RESERVED_B, POS_MIN, POS_MAX);
    settle();

    // no idling, with the receiver holding off long enough to back up the input
    hold_req <= 1'b1;
    run_random(PHASE_ITEMS);
    settle();
    idle_pct = 78;
    run_random(PHASE_ITEMS);
    settle();
    idle_pct = 0;
    stall_pct <= 78;
    run_random(PHASE_ITEMS);
    settle();
    idle_pct = 36;
    stall_pct <= 36;
    run_random(PHASE_ITEMS);

    // steepest slope with the most negative Y: busy count saturates, block stays busy
    run_until_idle();
    send_word(talsg_pkg::CMD_MOVE_REL, talsg_pkg::POS_BITS'(1), POS_MIN);
    repeat (6) send_word(talsg_pkg::CMD_TICK, '0, '0);
    send_word(talsg_pkg::CMD_MOVE_REL, POS_MAX, POS_MAX);
    send_word(talsg_pkg::CMD_MOVE_ABS, '0, '0);
    send_word(talsg_pkg::CMD_SET_POS, talsg_pkg::POS_BITS'($urandom()),
              talsg_pkg::POS_BITS'($urandom()));
    send_word(talsg_pkg::CMD_DISABLE, '0, '0);
    settle();
    repeat (SETTLE_SPAN) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[two_axis_line_step_generator_top.f]
src/talsg_pkg.sv
src/talsg_div.sv
src/two_axis_line_step_generator_top.sv
verif/step_checker.sv
verif/tb.sv
